// File: design/pip_pkg.sv
// shared types and constants for the point in polygon test unit
// no dependencies
package pip_pkg;

	localparam int CFG_W = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	typedef struct packed {
		logic valid;
		logic parity;
		logic edge_hit;
		logic dy_pos;
	} ctl_t;

endpackage

// File: design/pip_cell.sv
// one cell of the edge walking chain: holds one vertex, finishes the compare of the
// previous edge and forms the cross products of its own edge
// depends on pip_pkg
module pip_cell #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic signed [COORD_BITS-1:0]   wr_x,
	input  logic signed [COORD_BITS-1:0]   wr_y,
	input  logic                           active,
	input  pip_pkg::ctl_t                  ctl_in,
	input  logic signed [COORD_BITS-1:0]   px_in,
	input  logic signed [COORD_BITS-1:0]   py_in,
	input  logic signed [COORD_BITS-1:0]   xj_in,
	input  logic signed [COORD_BITS-1:0]   yj_in,
	input  logic signed [2*COORD_BITS+1:0] lp_in,
	input  logic signed [2*COORD_BITS+1:0] rp_in,
	output pip_pkg::ctl_t                  ctl_out,
	output logic signed [COORD_BITS-1:0]   px_out,
	output logic signed [COORD_BITS-1:0]   py_out,
	output logic signed [COORD_BITS-1:0]   xi,
	output logic signed [COORD_BITS-1:0]   yi,
	output logic signed [2*COORD_BITS+1:0] lp_out,
	output logic signed [2*COORD_BITS+1:0] rp_out
);

	localparam int PROD_W = 2 * COORD_BITS + 2;

	logic signed [COORD_BITS-1:0]   x_q;
	logic signed [COORD_BITS-1:0]   y_q;
	logic signed [COORD_BITS:0]     dx_pt;
	logic signed [COORD_BITS:0]     dy_edge;
	logic signed [COORD_BITS:0]     dx_edge;
	logic signed [COORD_BITS:0]     dy_pt;
	logic signed [2*COORD_BITS+1:0] lp;
	logic signed [2*COORD_BITS+1:0] rp;
	logic                           left;
	logic                           straddle;
	pip_pkg::ctl_t                  ctl_q;
	logic signed [COORD_BITS-1:0]   px_q;
	logic signed [COORD_BITS-1:0]   py_q;
	logic signed [2*COORD_BITS+1:0] lp_q;
	logic signed [2*COORD_BITS+1:0] rp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end
	end

	// compare of the edge handed in by the previous cell
	assign left = ctl_in.dy_pos ? (lp_in < rp_in) : (rp_in < lp_in);

	// this cell's edge runs from the previous vertex to its own
	assign dx_pt    = (COORD_BITS+1)'(px_in) - (COORD_BITS+1)'(x_q);
	assign dy_edge  = (COORD_BITS+1)'(yj_in) - (COORD_BITS+1)'(y_q);
	assign dx_edge  = (COORD_BITS+1)'(xj_in) - (COORD_BITS+1)'(x_q);
	assign dy_pt    = (COORD_BITS+1)'(py_in) - (COORD_BITS+1)'(y_q);
	assign lp       = PROD_W'(dx_pt) * PROD_W'(dy_edge);
	assign rp       = PROD_W'(dx_edge) * PROD_W'(dy_pt);
	assign straddle = (y_q > py_in) != (yj_in > py_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid    <= ctl_in.valid;
			ctl_q.parity   <= ctl_in.parity ^ (ctl_in.edge_hit & left);
			ctl_q.edge_hit <= active & straddle;
			ctl_q.dy_pos   <= yj_in > y_q;
		end
	end

	always_ff @(posedge clk) begin
		px_q <= px_in;
		py_q <= py_in;
		lp_q <= lp;
		rp_q <= rp;
	end

	assign ctl_out = ctl_q;
	assign px_out  = px_q;
	assign py_out  = py_q;
	assign lp_out  = lp_q;
	assign rp_out  = rp_q;
	assign xi      = x_q;
	assign yi      = y_q;

endmodule

// File: design/point_in_polygon_test_unit.sv
// top level of the crossing number point in polygon test unit
// depends on pip_pkg and pip_cell
//
// usage: one input channel (in_valid / in_stall) carries either a vertex write
// (operation 0: vertex_index, vertex_x, vertex_y) or a point test (operation 1:
// point_x, point_y). a write takes effect at its transfer and gives no result.
// a test gives one inside_res on the output channel (out_valid / out_stall).
// the vertex count register is written over cfg_valid / cfg_ready / cfg_data;
// the user must write it only while the unit is idle, as the block itself does
// not enforce it. counts above MAX_VERTICES saturate. vertices live in a row of
// MAX_VERTICES cells plus one closing cell; a test point walks the row one
// cell per cycle, each cell forming the cross products of its edge and the
// next cell finishing the compare and the parity. the parity of the last cell
// is registered into the output. a new test or write is not taken until the
// last test's result has reached the output register (in_stall high meanwhile).
// a waiting result does not block a new transfer; a stalled receiver holds the
// result, and a second finished result waits in a one entry hold register,
// with in_stall high until it moves on.
// reset clears the count to zero and empties the row; vertices are undefined
// until written.
module point_in_polygon_test_unit #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [3:0]                   vertex_index,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         inside_res,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pip_pkg::CFG_W-1:0]    cfg_data
);

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int N_W    = $clog2(MAX_VERTICES + 1);
	localparam int PROD_W = 2 * COORD_BITS + 2;

	logic [pip_pkg::CFG_W-1:0] count_q;
	logic [N_W-1:0]            n_used;
	logic [IDX_W-1:0]          last_idx;
	logic                      in_xfer;
	logic                      test_xfer;
	logic                      busy_q;
	logic                      out_valid_q;
	logic                      res_q;
	logic                      pend_valid_q;
	logic                      pend_q;
	logic                      out_free;
	logic                      done;

	pip_pkg::ctl_t               ctl [0:MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] px  [0:MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] py  [0:MAX_VERTICES+1];
	logic signed [PROD_W-1:0]     lp  [0:MAX_VERTICES+1];
	logic signed [PROD_W-1:0]     rp  [0:MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] xv  [0:MAX_VERTICES];
	logic signed [COORD_BITS-1:0] yv  [0:MAX_VERTICES];

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_xfer   = in_valid & ~in_stall;
	assign test_xfer = in_xfer & (operation == pip_pkg::OP_TEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(count_q) > MAX_VERTICES) begin
			n_used = N_W'(MAX_VERTICES);
		end else begin
			n_used = N_W'(count_q);
		end
		last_idx = IDX_W'(n_used - N_W'(1));
	end

	// entry to the row: the closing edge starts from the last vertex in use
	assign ctl[0].valid    = test_xfer;
	assign ctl[0].parity   = 1'b0;
	assign ctl[0].edge_hit = 1'b0;
	assign ctl[0].dy_pos   = 1'b0;
	assign px[0]           = point_x;
	assign py[0]           = point_y;
	assign lp[0]           = '0;
	assign rp[0]           = '0;

	for (genvar k = 0; k <= MAX_VERTICES; k++) begin : g_cell
		logic                         wr_en;
		logic                         active;
		logic signed [COORD_BITS-1:0] xj;
		logic signed [COORD_BITS-1:0] yj;

		if (k < MAX_VERTICES) begin : g_vtx
			assign wr_en  = in_xfer && (operation == pip_pkg::OP_WRITE)
			                && (32'(vertex_index) == k);
			assign active = 32'(n_used) > k;
		end else begin : g_close
			assign wr_en  = 1'b0;
			assign active = 1'b0;
		end

		if (k == 0) begin : g_first
			assign xj = xv[last_idx];
			assign yj = yv[last_idx];
		end else begin : g_next
			assign xj = xv[k-1];
			assign yj = yv[k-1];
		end

		pip_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (wr_en),
			.wr_x   (vertex_x),
			.wr_y   (vertex_y),
			.active (active),
			.ctl_in (ctl[k]),
			.px_in  (px[k]),
			.py_in  (py[k]),
			.xj_in  (xj),
			.yj_in  (yj),
			.lp_in  (lp[k]),
			.rp_in  (rp[k]),
			.ctl_out(ctl[k+1]),
			.px_out (px[k+1]),
			.py_out (py[k+1]),
			.xi     (xv[k]),
			.yi     (yv[k]),
			.lp_out (lp[k+1]),
			.rp_out (rp[k+1])
		);
	end

	assign done     = ctl[MAX_VERTICES+1].valid;
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (test_xfer) begin
				busy_q <= 1'b1;
			end
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
					busy_q       <= 1'b0;
				end else if (done) begin
					out_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (done) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				res_q <= pend_q;
			end else if (done) begin
				res_q <= ctl[MAX_VERTICES+1].parity;
			end
		end else if (done) begin
			pend_q <= ctl[MAX_VERTICES+1].parity;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = res_q;

endmodule
